FILE: rtl/trial_division_factorizer_macros.svh
// Assertion macros for the checker file
`ifndef TRIAL_DIVISION_FACTORIZER_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TDF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("factorizer check failed");

// Next-cycle implication, disabled during reset
`define TDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("factorizer check failed");

`endif

FILE: rtl/tdf_pkg.sv
package tdf_pkg;

  localparam int WIDTH = 32;
  localparam int CntW  = $clog2(WIDTH);

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_TWOS  = 5'b00100,
    S_DIV   = 5'b01000,
    S_EVAL  = 5'b10000
  } ctrl_state_e;

  // Source of an emitted factor
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_TWO  = 2'd1,
    EMIT_DIV  = 2'd2,
    EMIT_REM  = 2'd3
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      shift_two;
    logic      init_div;
    logic      next_div;
    logic      take_quot;
    logic      div_start;
    logic      emit;
    emit_sel_e sel;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic r_lt2;
    logic r_even;
    logic r_is2;
    logic r_gt1;
    logic div_done;
    logic d_gt_q;
    logic rem_zero;
    logic q_is1;
    logic slot_free;
  } dp_stat_t;

endpackage

FILE: rtl/tdf_div.sv
module tdf_div
  import tdf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [WIDTH-1:0] quo_q, rem_q, dvs_q;
  logic [WIDTH:0]   shifted, diff;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_q, quo_q[WIDTH-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = ~diff[WIDTH];
  end

  // Sequence the steps, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CntW'(WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[WIDTH-2:0], ge};
      rem_q <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/tdf_datapath.sv
module tdf_datapath
  import tdf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_stat_t         stat_o,
  input  logic [WIDTH-1:0] in_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] out_factor_o,
  output logic             out_last_o,
  output logic             out_none_o
);

  logic [WIDTH-1:0] rem_val_q, rem_val_d;
  logic [WIDTH-1:0] div_q, div_d;
  logic [WIDTH-1:0] quot, drem;
  logic             div_done;
  logic             out_valid_q;
  logic [WIDTH-1:0] factor_q, factor_d;
  logic             last_q, none_q;

  // Next remaining value and trial divisor
  always_comb begin
    rem_val_d = rem_val_q;
    if (cmd_i.load) begin
      rem_val_d = in_value_i;
    end else if (cmd_i.shift_two) begin
      rem_val_d = {1'b0, rem_val_q[WIDTH-1:1]};
    end else if (cmd_i.take_quot) begin
      rem_val_d = quot;
    end
    div_d = div_q;
    if (cmd_i.init_div) begin
      div_d = WIDTH'(3);
    end else if (cmd_i.next_div) begin
      div_d = div_q + WIDTH'(2);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_val_q <= rem_val_d;
    div_q     <= div_d;
  end

  // Divider works on the values being written this cycle
  tdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rem_val_d),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (drem)
  );

  // Pick the factor to emit
  always_comb begin
    case (cmd_i.sel)
      EMIT_TWO: factor_d = WIDTH'(2);
      EMIT_DIV: factor_d = div_q;
      EMIT_REM: factor_d = rem_val_q;
      default:  factor_d = '0;
    endcase
  end

  // Output register: load on emit, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      factor_q <= factor_d;
      last_q   <= cmd_i.emit_last;
      none_q   <= (cmd_i.sel == EMIT_NONE);
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.r_lt2     = (rem_val_q < WIDTH'(2));
    stat_o.r_even    = ~rem_val_q[0];
    stat_o.r_is2     = (rem_val_q == WIDTH'(2));
    stat_o.r_gt1     = (rem_val_q > WIDTH'(1));
    stat_o.div_done  = div_done;
    stat_o.d_gt_q    = (div_q > quot);
    stat_o.rem_zero  = (drem == '0);
    stat_o.q_is1     = (quot == WIDTH'(1));
    stat_o.slot_free = ~out_valid_q | ~out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_factor_o = factor_q;
  assign out_last_o   = last_q;
  assign out_none_o   = none_q;

endmodule

FILE: rtl/tdf_ctrl.sv
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence: small-value check, strip twos, then odd trial divisors
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = EMIT_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (stat_i.r_lt2) begin
          if (stat_i.slot_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.sel       = EMIT_NONE;
            cmd_o.emit_last = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          state_d = S_TWOS;
        end
      end
      S_TWOS: begin
        if (stat_i.r_even) begin
          if (stat_i.slot_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.sel       = EMIT_TWO;
            cmd_o.emit_last = stat_i.r_is2;
            cmd_o.shift_two = 1'b1;
            if (stat_i.r_is2) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          cmd_o.init_div  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.d_gt_q) begin
          // Divisor past the square root: what is left is prime
          if (stat_i.r_gt1) begin
            if (stat_i.slot_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.sel       = EMIT_REM;
              cmd_o.emit_last = 1'b1;
              state_d         = S_IDLE;
            end
          end else begin
            state_d = S_IDLE;
          end
        end else if (stat_i.rem_zero) begin
          if (stat_i.slot_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.sel       = EMIT_DIV;
            cmd_o.emit_last = stat_i.q_is1;
            cmd_o.take_quot = 1'b1;
            if (stat_i.q_is1) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
        end else begin
          cmd_o.next_div  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/trial_division_factorizer.sv
// Channel | Handshake             | Payload
// --------+-----------------------+-------------------------------------------
// in      | in_valid_i/in_stall_o | in_value_i
// out     | out_valid_o/out_stall_i | out_factor_o, out_last_o, out_none_o
//
// One item at a time; each odd trial divisor costs one restoring division plus
// control, on the shared bit-serial divider. Worst case about 32768 divisors.
// Reset is asynchronous, active low, and clears controller, divider and output valid.
// A stalled output holds the sequencer at an emit; the input stalls while an item is in progress.
module trial_division_factorizer
  import tdf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] in_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] out_factor_o,
  output logic             out_last_o,
  output logic             out_none_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tdf_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_value_i   (in_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_factor_o (out_factor_o),
    .out_last_o   (out_last_o),
    .out_none_o   (out_none_o)
  );

endmodule

FILE: rtl/tdf_checker.sv
`include "trial_division_factorizer_macros.svh"

module tdf_checker
  import tdf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WIDTH-1:0] out_factor_o,
  input logic             out_last_o,
  input logic             out_none_o
);

  logic             in_xfer;
  logic             out_held;
  logic             factor_out;
  logic             none_form;
  logic [WIDTH+1:0] out_word;

  // Gather the terms the checks look at
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_held   = out_valid_o && out_stall_i;
  assign factor_out = out_valid_o && !out_none_o;
  assign none_form  = out_last_o && (out_factor_o == '0);
  assign out_word   = {out_factor_o, out_last_o, out_none_o};

  // A result without factors is the only result of its item and carries zero
  `TDF_ASSERT_SAME(a_none_form, clk_i, rst_ni, out_valid_o && out_none_o, none_form)

  // Any real factor is at least two
  `TDF_ASSERT_SAME(a_factor_min, clk_i, rst_ni, factor_out, out_factor_o > WIDTH'(1))

  // A transferred input keeps the block busy on the next cycle
  `TDF_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer, in_stall_o)

  // A stalled result holds
  `TDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word))

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (.*);
